// ----- hdl/usr_pkg.sv -----
// shared types, request codes and result codes of the standard request handler
package usr_pkg;

  localparam int NUM_STRINGS_DEF = 4;
  localparam int MAX_PACKET_DEF  = 64;
  localparam int Q_DEPTH         = 2;
  localparam int ADDR_W          = 5;
  localparam int DATA_W          = 32;

  // bmRequestType values
  localparam logic [7:0] TYPE_MASK    = 8'h60;
  localparam logic [7:0] RT_DEV_OUT   = 8'h00;
  localparam logic [7:0] RT_EP_OUT    = 8'h02;
  localparam logic [7:0] RT_DEV_IN    = 8'h80;
  localparam logic [7:0] RT_IF_IN     = 8'h81;
  localparam logic [7:0] RT_EP_IN     = 8'h82;

  // bRequest values
  localparam logic [7:0] REQ_GET_STATUS     = 8'h00;
  localparam logic [7:0] REQ_CLEAR_FEATURE  = 8'h01;
  localparam logic [7:0] REQ_SET_FEATURE    = 8'h03;
  localparam logic [7:0] REQ_SET_ADDRESS    = 8'h05;
  localparam logic [7:0] REQ_GET_DESC       = 8'h06;
  localparam logic [7:0] REQ_GET_CONFIG     = 8'h08;
  localparam logic [7:0] REQ_SET_CONFIG     = 8'h09;
  localparam logic [7:0] REQ_GET_INTERFACE  = 8'h0A;
  localparam logic [7:0] REQ_SET_INTERFACE  = 8'h0B;

  // descriptor types
  localparam logic [7:0] DT_DEVICE = 8'h01;
  localparam logic [7:0] DT_CONFIG = 8'h02;
  localparam logic [7:0] DT_STRING = 8'h03;
  localparam logic [7:0] DT_HID    = 8'h21;
  localparam logic [7:0] DT_REPORT = 8'h22;

  // feature selectors and endpoint
  localparam logic [7:0] FEAT_EP_HALT     = 8'h00;
  localparam logic [7:0] FEAT_REMOTE_WAKE = 8'h01;
  localparam logic [7:0] EP3_IN_ADDR      = 8'h83;

  // result codes
  localparam logic [1:0] RESP_STALL = 2'd0;
  localparam logic [1:0] RESP_ACK   = 2'd1;
  localparam logic [1:0] RESP_DATA  = 2'd2;

  localparam logic [2:0] SRC_INLINE = 3'd0;
  localparam logic [2:0] SRC_DEVICE = 3'd1;
  localparam logic [2:0] SRC_CONFIG = 3'd2;
  localparam logic [2:0] SRC_STRING = 3'd3;
  localparam logic [2:0] SRC_HID    = 3'd4;
  localparam logic [2:0] SRC_REPORT = 3'd5;

  // register indexes
  localparam logic [2:0] REG_DEVICE_LEN = 3'd0;
  localparam logic [2:0] REG_CONFIG_LEN = 3'd1;
  localparam logic [2:0] REG_HID_LEN    = 3'd2;
  localparam logic [2:0] REG_REPORT_LEN = 3'd3;
  localparam logic [2:0] REG_STRING_LEN = 3'd4;

  typedef enum logic [3:0] {
    OP_STALL,
    OP_DATA,
    OP_ACK,
    OP_HALT_SET,
    OP_HALT_CLR,
    OP_WAKE_SET,
    OP_WAKE_CLR,
    OP_STATUS_DEV,
    OP_STATUS_EP,
    OP_GET_CONFIG,
    OP_SET_CONFIG
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [6:0] dlen;
    logic [2:0] src;
    logic [1:0] ssel;
    logic [7:0] arg;
  } cmd_t;

  typedef struct packed {
    logic [1:0] response;
    logic [6:0] data_len;
    logic [7:0] reply_byte0;
    logic [2:0] reply_source;
    logic [1:0] string_select;
    logic       ep3_halt;
    logic       clear_ep3_toggle;
    logic       wakeup_enabled;
    logic [7:0] config_current;
    logic       suspend_watch;
  } result_t;

endpackage

// ----- hdl/usr_front.sv -----
// request classifier: turns a setup packet into a command for the back end
module usr_front #(
  parameter int NUM_STRINGS = usr_pkg::NUM_STRINGS_DEF,
  parameter int MAX_PACKET  = usr_pkg::MAX_PACKET_DEF
) (
  input  logic [7:0]  request_type,
  input  logic [7:0]  request_code,
  input  logic [7:0]  value_low,
  input  logic [7:0]  value_high,
  input  logic [7:0]  index_low,
  input  logic [15:0] requested_len,
  input  logic [6:0]  device_desc_len,
  input  logic [6:0]  config_desc_len,
  input  logic [6:0]  hid_desc_len,
  input  logic [6:0]  report_desc_len,
  input  logic [31:0] string_desc_lens,
  output usr_pkg::cmd_t cmd
);
  import usr_pkg::*;

  logic [7:0] desc;
  logic [7:0] sat;
  logic [2:0] dsrc;
  logic [1:0] dsel;
  logic [6:0] clipped;

  // descriptor length lookup
  always_comb begin
    desc = 8'd0;
    dsrc = SRC_INLINE;
    dsel = 2'd0;
    unique case (value_high)
      DT_DEVICE: begin
        desc = {1'b0, device_desc_len};
        dsrc = SRC_DEVICE;
      end
      DT_CONFIG: begin
        desc = {1'b0, config_desc_len};
        dsrc = SRC_CONFIG;
      end
      DT_STRING: begin
        if (value_low < 8'(NUM_STRINGS)) begin
          desc = string_desc_lens[8*value_low[1:0] +: 8];
          dsrc = SRC_STRING;
          dsel = value_low[1:0];
        end
      end
      DT_HID: begin
        desc = {1'b0, hid_desc_len};
        dsrc = SRC_HID;
      end
      DT_REPORT: begin
        desc = {1'b0, report_desc_len};
        dsrc = SRC_REPORT;
      end
      default: ;
    endcase
  end

  // saturate to packet size, then clip to wLength
  always_comb begin
    sat     = (desc > 8'(MAX_PACKET)) ? 8'(MAX_PACKET) : desc;
    clipped = (requested_len < {8'd0, sat}) ? requested_len[6:0] : sat[6:0];
  end

  always_comb begin
    cmd      = '0;
    cmd.op   = OP_STALL;
    cmd.arg  = value_low;
    if ((request_type & TYPE_MASK) == 8'd0) begin
      unique case (request_code)
        REQ_GET_DESC: begin
          if (desc != 8'd0) begin
            cmd.op   = OP_DATA;
            cmd.dlen = clipped;
            cmd.src  = dsrc;
            cmd.ssel = dsel;
          end
        end
        REQ_SET_FEATURE, REQ_CLEAR_FEATURE: begin
          if (request_type == RT_EP_OUT && value_low == FEAT_EP_HALT &&
              index_low == EP3_IN_ADDR) begin
            cmd.op = (request_code == REQ_SET_FEATURE) ? OP_HALT_SET : OP_HALT_CLR;
          end else if (request_type == RT_DEV_OUT && value_low == FEAT_REMOTE_WAKE) begin
            cmd.op = (request_code == REQ_SET_FEATURE) ? OP_WAKE_SET : OP_WAKE_CLR;
          end
        end
        REQ_GET_STATUS: begin
          cmd.dlen = 7'd2;
          if (request_type == RT_DEV_IN) begin
            cmd.op = OP_STATUS_DEV;
          end else if (request_type == RT_IF_IN) begin
            cmd.op = OP_DATA;
          end else if (request_type == RT_EP_IN && index_low == EP3_IN_ADDR) begin
            cmd.op = OP_STATUS_EP;
          end else begin
            cmd.dlen = 7'd0;
          end
        end
        REQ_SET_INTERFACE: begin
          if (value_low == 8'd0 && index_low == 8'd0) cmd.op = OP_ACK;
        end
        REQ_GET_INTERFACE: begin
          if (index_low == 8'd0) begin
            cmd.op   = OP_DATA;
            cmd.dlen = 7'd1;
          end
        end
        REQ_GET_CONFIG: begin
          cmd.op   = OP_GET_CONFIG;
          cmd.dlen = 7'd1;
        end
        REQ_SET_CONFIG:  cmd.op = OP_SET_CONFIG;
        REQ_SET_ADDRESS: cmd.op = OP_ACK;
        default: ;
      endcase
    end
  end

endmodule

// ----- hdl/usr_queue.sv -----
// short command queue between classifier and executor
module usr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  usr_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output usr_pkg::cmd_t head
);
  import usr_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

  cmd_t             slots [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full      = (count == (PTR_W+1)'(Q_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

endmodule

// ----- hdl/usr_back.sv -----
// executor: applies commands to device state and holds the result register
module usr_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  input  usr_pkg::cmd_t    cmd,
  output logic             cmd_pop,
  output logic             result_valid,
  input  logic             result_ready,
  output usr_pkg::result_t result
);
  import usr_pkg::*;

  logic [7:0] config_value, config_value_next;
  logic       wake_on, wake_on_next;
  logic       halted, halted_next;
  logic       watch_on, watch_on_next;
  logic       toggle;
  logic [1:0] resp;
  logic [7:0] b0;

  assign cmd_pop = cmd_valid && (!result_valid || result_ready);

  always_comb begin
    config_value_next = config_value;
    wake_on_next      = wake_on;
    halted_next       = halted;
    watch_on_next     = watch_on;
    toggle            = 1'b0;
    resp              = RESP_STALL;
    b0                = 8'd0;
    unique case (cmd.op)
      OP_STALL: ;
      OP_DATA:  resp = RESP_DATA;
      OP_ACK:   resp = RESP_ACK;
      OP_HALT_SET: begin
        halted_next = 1'b1;
        resp        = RESP_ACK;
      end
      OP_HALT_CLR: begin
        halted_next = 1'b0;
        toggle      = 1'b1;
        resp        = RESP_ACK;
      end
      OP_WAKE_SET: begin
        wake_on_next = 1'b1;
        resp         = RESP_ACK;
      end
      OP_WAKE_CLR: begin
        wake_on_next = 1'b0;
        resp         = RESP_ACK;
      end
      OP_STATUS_DEV: begin
        resp = RESP_DATA;
        b0   = {6'd0, wake_on, 1'b1};
      end
      OP_STATUS_EP: begin
        resp = RESP_DATA;
        b0   = {7'd0, halted};
      end
      OP_GET_CONFIG: begin
        resp = RESP_DATA;
        b0   = config_value;
      end
      OP_SET_CONFIG: begin
        config_value_next = cmd.arg;
        if (cmd.arg != 8'd0) watch_on_next = 1'b1;
        resp = RESP_ACK;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      config_value <= 8'd0;
      wake_on      <= 1'b0;
      halted       <= 1'b0;
      watch_on     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cmd_pop) begin
        config_value <= config_value_next;
        wake_on      <= wake_on_next;
        halted       <= halted_next;
        watch_on     <= watch_on_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      result.response         <= resp;
      result.data_len         <= cmd.dlen;
      result.reply_byte0      <= b0;
      result.reply_source     <= cmd.src;
      result.string_select    <= cmd.ssel;
      result.ep3_halt         <= halted_next;
      result.clear_ep3_toggle <= toggle;
      result.wakeup_enabled   <= wake_on_next;
      result.config_current   <= config_value_next;
      result.suspend_watch    <= watch_on_next;
    end
  end

endmodule

// ----- hdl/usb_standard_request_handler.sv -----
// endpoint-0 standard request handler, top level with register port
//
// takes one 8-byte setup packet per transfer on the setup channel
// (setup_valid / setup_ready) and gives one answer per packet on the
// result channel (result_valid / result_ready): stall, status acknowledge
// or data stage with inline bytes or a descriptor source
// the front classifier decodes the packet in the cycle it is accepted and
// writes a command into a two-entry queue; the back executor pops it,
// updates configuration, remote wakeup, endpoint 3 halt and suspend watch,
// and loads the result register
// the command passes through the queue and then the result register before
// result_valid rises; throughput is one packet per cycle while the result side
// keeps taking transfers
// when the receiver stalls the result register holds, the queue fills
// and setup_ready drops once both queue entries are taken
// reset is synchronous: it empties the queue and the result register,
// clears all device state and loads the descriptor length defaults
// descriptor lengths sit behind the apb port (byte address 4 * index);
// the user must write them only while no packet is in flight, unchecked by the block
module usb_standard_request_handler #(
  parameter int NUM_STRINGS = usr_pkg::NUM_STRINGS_DEF,
  parameter int MAX_PACKET  = usr_pkg::MAX_PACKET_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // register port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [usr_pkg::ADDR_W-1:0] paddr,
  input  logic [usr_pkg::DATA_W-1:0] pwdata,
  output logic [usr_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  // setup channel
  input  logic                       setup_valid,
  output logic                       setup_ready,
  input  logic [7:0]                 request_type,
  input  logic [7:0]                 request_code,
  input  logic [7:0]                 value_low,
  input  logic [7:0]                 value_high,
  input  logic [7:0]                 index_low,
  input  logic [7:0]                 index_high,
  input  logic [15:0]                requested_len,
  // result channel
  output logic                       result_valid,
  input  logic                       result_ready,
  output logic [1:0]                 response,
  output logic [6:0]                 data_len,
  output logic [7:0]                 reply_byte0,
  output logic [7:0]                 reply_byte1,
  output logic [2:0]                 reply_source,
  output logic [1:0]                 string_select,
  output logic                       ep3_halt,
  output logic                       clear_ep3_toggle,
  output logic                       wakeup_enabled,
  output logic [7:0]                 config_current,
  output logic                       suspend_watch
);
  import usr_pkg::*;

  logic [6:0]  device_desc_len;
  logic [6:0]  config_desc_len;
  logic [6:0]  hid_desc_len;
  logic [6:0]  report_desc_len;
  logic [31:0] string_desc_lens;
  logic [2:0]  reg_idx;
  logic        reg_wr;

  cmd_t    front_cmd;
  cmd_t    head_cmd;
  logic    q_full;
  logic    q_valid;
  logic    q_pop;
  result_t result;

  // register port: always ready, word addressed
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign reg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_desc_len  <= 7'd18;
      config_desc_len  <= 7'd34;
      hid_desc_len     <= 7'd9;
      report_desc_len  <= 7'd52;
      string_desc_lens <= 32'd4;
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_DEVICE_LEN: device_desc_len  <= pwdata[6:0];
        REG_CONFIG_LEN: config_desc_len  <= pwdata[6:0];
        REG_HID_LEN:    hid_desc_len     <= pwdata[6:0];
        REG_REPORT_LEN: report_desc_len  <= pwdata[6:0];
        REG_STRING_LEN: string_desc_lens <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DEVICE_LEN: prdata = {25'd0, device_desc_len};
      REG_CONFIG_LEN: prdata = {25'd0, config_desc_len};
      REG_HID_LEN:    prdata = {25'd0, hid_desc_len};
      REG_REPORT_LEN: prdata = {25'd0, report_desc_len};
      REG_STRING_LEN: prdata = string_desc_lens;
      default:        prdata = '0;
    endcase
  end

  // front: classify the packet as it is taken
  usr_front #(
    .NUM_STRINGS(NUM_STRINGS),
    .MAX_PACKET (MAX_PACKET)
  ) u_front (
    .request_type    (request_type),
    .request_code    (request_code),
    .value_low       (value_low),
    .value_high      (value_high),
    .index_low       (index_low),
    .requested_len   (requested_len),
    .device_desc_len (device_desc_len),
    .config_desc_len (config_desc_len),
    .hid_desc_len    (hid_desc_len),
    .report_desc_len (report_desc_len),
    .string_desc_lens(string_desc_lens),
    .cmd             (front_cmd)
  );

  // wIndex high byte plays no part in any standard request handled here
  assign setup_ready = !q_full;

  usr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (setup_valid && setup_ready),
    .push_cmd (front_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_valid),
    .head     (head_cmd)
  );

  usr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (q_valid),
    .cmd         (head_cmd),
    .cmd_pop     (q_pop),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  assign response         = result.response;
  assign data_len         = result.data_len;
  assign reply_byte0      = result.reply_byte0;
  assign reply_byte1      = 8'd0;
  assign reply_source     = result.reply_source;
  assign string_select    = result.string_select;
  assign ep3_halt         = result.ep3_halt;
  assign clear_ep3_toggle = result.clear_ep3_toggle;
  assign wakeup_enabled   = result.wakeup_enabled;
  assign config_current   = result.config_current;
  assign suspend_watch    = result.suspend_watch;

endmodule

// ----- hdl/usr_checker.sv -----
// port-level checks of the standard request handler, bound to the top level
module usr_checker (
  input logic       clk,
  input logic       rst,
  input logic       result_valid,
  input logic       result_ready,
  input logic [1:0] response,
  input logic [6:0] data_len,
  input logic [7:0] reply_byte0,
  input logic [2:0] reply_source,
  input logic [1:0] string_select,
  input logic       ep3_halt,
  input logic       clear_ep3_toggle,
  input logic       suspend_watch
);
  import usr_pkg::*;

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result dropped while stalled");

  // only a data stage carries length or a descriptor source
  a_no_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && response != RESP_DATA |->
      data_len == 7'd0 && reply_source == SRC_INLINE && string_select == 2'd0)
    else $error("length or source on a non-data answer");

  // a toggle clear goes with a cleared halt and an acknowledge
  a_toggle: assert property (@(posedge clk) disable iff (rst)
    result_valid && clear_ep3_toggle |-> !ep3_halt && response == RESP_ACK)
    else $error("toggle clear without halt clear");

  // suspend watch never falls once set
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && suspend_watch ##1 result_valid |-> suspend_watch)
    else $error("suspend watch fell");

  // a descriptor answer carries no inline byte
  a_desc_inline: assert property (@(posedge clk) disable iff (rst)
    result_valid && reply_source != SRC_INLINE |-> reply_byte0 == 8'd0)
    else $error("inline byte on descriptor answer");

endmodule

bind usb_standard_request_handler usr_checker u_usr_checker (.*);
